// ===== hw/rtl/ecd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecd_pkg
// shared types, constants and calendar helpers for the epoch to date unit
// ----------------------------------------------------------------------------
`default_nettype none

package ecd_pkg;

  localparam int unsigned AluW  = 32;
  localparam int unsigned BaseW = 17;
  localparam int unsigned ShW   = 4;
  localparam int unsigned YearW = 12;

  localparam logic [BaseW-1:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [BaseW-1:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [BaseW-1:0] SEC_PER_MIN   = 17'd60;
  localparam logic [BaseW-1:0] DAYS_PER_WEEK = 17'd7;

  localparam logic [YearW-1:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [YearW-1:0] CENTURY_2000  = 12'd2000;
  localparam logic [YearW-1:0] CENTURY_1900  = 12'd1900;
  localparam logic [YearW-1:0] NOLEAP_2100   = 12'd2100;
  localparam logic [15:0]      EPOCH_WDAY_OFS = 16'd4;

  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [AluW-1:0]  a;
    logic [BaseW-1:0] base;
    logic [ShW-1:0]   sh;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] diff;
    logic            ge;
  } alu_rsp_t;

  // valid over 1970..2106, where 2100 is the only century year that is not leap
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00) && (y != NOLEAP_2100);
  endfunction

  function automatic logic [8:0] year_days(input logic [YearW-1:0] y);
    return is_leap(y) ? DAYS_LEAP : DAYS_COMMON;
  endfunction

  function automatic logic [4:0] month_days(input logic [YearW-1:0] y,
                                            input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MONTH_FEB:                                 len = is_leap(y) ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [6:0] year_code(input logic [YearW-1:0] y);
    logic [YearW-1:0] d;
    d = (y >= CENTURY_2000) ? (y - CENTURY_2000) : (y - CENTURY_1900);
    return d[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_calendar_date_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_unit
// breaks a 32-bit unsigned epoch second count into weekday, date and time
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. busy then stays high
// while one shared subtract/compare unit runs every step: 16 steps divide by
// the seconds of a day, 13 reduce the day count modulo 7, 5 and 6 split the
// seconds of the day into hours and minutes, then one step per whole year
// elapsed since 1970 (0..136) plus a stop step and one step per month up to
// the resulting month (1..12). The result is held on the out_ ports and
// marked by out_valid for one cycle, in which busy is already low and a new
// start is taken. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_date_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  output logic [6:0]       out_year_code,
  output logic [3:0]       out_month_number,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour_of_day,
  output logic [5:0]       out_minute_of_hour,
  output logic [5:0]       out_second_of_minute,
  output logic [2:0]       out_weekday
);

  typedef enum logic [2:0] {
    S_IDLE, S_DAYS, S_WDAY, S_HOUR, S_MIN, S_YEAR, S_MONTH
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] days_r, days_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [6:0] year_code_r, year_code_nxt;
  logic [3:0] month_o_r, month_o_nxt;
  logic [4:0] mday_r, mday_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [2:0] wday_r, wday_nxt;

  ecd_pkg::alu_req_t alu_req;
  ecd_pkg::alu_rsp_t alu_rsp;

  logic [31:0] rem_step;
  logic [15:0] quo_step;
  logic        last_bit;

  ecd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign rem_step = alu_rsp.ge ? alu_rsp.diff : rem_r;
  assign quo_step = {quo_r[14:0], alu_rsp.ge};
  assign last_bit = (cnt_r == 4'd0);

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    days_nxt      = days_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    out_valid_nxt = 1'b0;
    year_code_nxt = year_code_r;
    month_o_nxt   = month_o_r;
    mday_nxt      = mday_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    wday_nxt      = wday_r;

    alu_req.a    = rem_r;
    alu_req.base = ecd_pkg::SEC_PER_DAY;
    alu_req.sh   = cnt_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          rem_nxt   = in_epoch_seconds;
          quo_nxt   = '0;
          cnt_nxt   = 4'd15;
          state_nxt = S_DAYS;
        end
      end
      S_DAYS: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (last_bit) begin
          days_nxt  = quo_step;
          rem_nxt   = {16'd0, quo_step} + {16'd0, ecd_pkg::EPOCH_WDAY_OFS};
          quo_nxt   = {15'd0, rem_step[16]};
          cnt_nxt   = 4'd12;
          state_nxt = S_WDAY;
        end
      end
      S_WDAY: begin
        // seconds of day wait in sod_r and days_r is untouched
        alu_req.base = ecd_pkg::DAYS_PER_WEEK;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 4'd1;
        if (last_bit) begin
          wday_nxt  = rem_step[2:0] + 3'd1;
          state_nxt = S_HOUR;
          cnt_nxt   = 4'd4;
        end
      end
      S_HOUR: begin
        alu_req.base = ecd_pkg::SEC_PER_HOUR;
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (last_bit) begin
          hour_nxt  = quo_step[4:0];
          cnt_nxt   = 4'd5;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        alu_req.base = ecd_pkg::SEC_PER_MIN;
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (last_bit) begin
          min_nxt   = quo_step[5:0];
          sec_nxt   = rem_step[5:0];
          year_nxt  = ecd_pkg::EPOCH_YEAR;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        alu_req.a    = {16'd0, days_r};
        alu_req.base = {8'd0, ecd_pkg::year_days(year_r)};
        alu_req.sh   = '0;
        if (alu_rsp.ge) begin
          days_nxt = alu_rsp.diff[15:0];
          year_nxt = year_r + 12'd1;
        end else begin
          month_nxt = ecd_pkg::MONTH_JAN;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        alu_req.a    = {16'd0, days_r};
        alu_req.base = {12'd0, ecd_pkg::month_days(year_r, month_r)};
        alu_req.sh   = '0;
        if ((month_r < ecd_pkg::MONTH_DEC) && alu_rsp.ge) begin
          days_nxt  = alu_rsp.diff[15:0];
          month_nxt = month_r + 4'd1;
        end else begin
          year_code_nxt = ecd_pkg::year_code(year_r);
          month_o_nxt   = month_r;
          mday_nxt      = days_r[4:0] + 5'd1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // the day split leaves seconds of day in rem_step; carry them into sod
  logic [16:0] sod_r, sod_nxt;

  always_comb begin
    sod_nxt = sod_r;
    if ((state_r == S_DAYS) && last_bit) begin
      sod_nxt = rem_step[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= ((state_r == S_WDAY) && last_bit) ? {15'd0, sod_r} : rem_nxt;
    quo_r       <= ((state_r == S_WDAY) && last_bit) ? 16'd0 : quo_nxt;
    cnt_r       <= cnt_nxt;
    days_r      <= days_nxt;
    sod_r       <= sod_nxt;
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    year_code_r <= year_code_nxt;
    month_o_r   <= month_o_nxt;
    mday_r      <= mday_nxt;
    hour_r      <= hour_nxt;
    min_r       <= min_nxt;
    sec_r       <= sec_nxt;
    wday_r      <= wday_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_year_code        = year_code_r;
  assign out_month_number     = month_o_r;
  assign out_day_of_month     = mday_r;
  assign out_hour_of_day      = hour_r;
  assign out_minute_of_hour   = min_r;
  assign out_second_of_minute = sec_r;
  assign out_weekday          = wday_r;

`ifndef ASSERT_OFF
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result beat");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not start the sequencer");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_number >= 4'd1) && (out_month_number <= 4'd12) &&
                  (out_day_of_month != 5'd0) && (out_weekday != 3'd0))
    else $error("result beat out of calendar range");

  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR) |-> (year_r <= 12'd2106))
    else $error("year search ran past the input range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ecd_alu.sv =====
// ----------------------------------------------------------------------------
// ecd_alu
// shared shift, subtract and compare unit used by every sequencer step
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_alu (
  input  ecd_pkg::alu_req_t req,
  output ecd_pkg::alu_rsp_t rsp
);

  logic [ecd_pkg::AluW-1:0] b;
  logic [ecd_pkg::AluW:0]   d;

  assign b = {{(ecd_pkg::AluW - ecd_pkg::BaseW){1'b0}}, req.base} << req.sh;
  assign d = {1'b0, req.a} - {1'b0, b};

  assign rsp.diff = d[ecd_pkg::AluW-1:0];
  assign rsp.ge   = ~d[ecd_pkg::AluW];

endmodule

`default_nettype wire

// ===== dv/epoch_seconds_to_calendar_date_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_unit_tb
// self-checking bench for the epoch second to calendar date unit
// ----------------------------------------------------------------------------
// Feeds 32-bit epoch second counts through the start/busy command port and
// compares every strobed date against a behavioral calendar model kept in
// the bench or, for four table rows, against a stored date. A short table
// covers the range ends, the 1999/2000 year code split, leap days and the
// non-leap year 2100. Random beats follow: uniform counts mixed with counts
// placed on year and month edges, with random gaps before each start.
// ----------------------------------------------------------------------------

module epoch_seconds_to_calendar_date_unit_tb;

  localparam int unsigned NUM_RANDOM  = 1050;
  localparam int unsigned NUM_DIR     = 23;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [31:0] Y2K_EPOCH   = 32'd946684800;

  typedef struct packed {
    logic [6:0] year_code;
    logic [3:0] month_number;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [2:0] weekday;
  } civil_date_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic        golden_ok;
    civil_date_t golden;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_epoch_seconds = '0;
  logic        busy;
  logic        out_valid;
  logic [6:0]  out_year_code;
  logic [3:0]  out_month_number;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;
  logic [2:0]  out_weekday;

  civil_date_t pending_dates [$];
  int unsigned beats_sent;
  int unsigned dates_checked;
  int unsigned pre2000_beats;
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;

  stim_row_t dir_rows [NUM_DIR] = '{
    {32'd0,          1'b1, 7'd70,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd5},
    {32'hFFFF_FFFF,  1'b1, 7'd106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15, 3'd1},
    {32'd946684799,  1'b1, 7'd99,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd6},
    {32'd946684800,  1'b1, 7'd0,   4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd7},
    {32'd1,          1'b0, 36'd0},
    {32'd59,         1'b0, 36'd0},
    {32'd60,         1'b0, 36'd0},
    {32'd3599,       1'b0, 36'd0},
    {32'd3600,       1'b0, 36'd0},
    {32'd86399,      1'b0, 36'd0},
    {32'd86400,      1'b0, 36'd0},
    {32'd172800,     1'b0, 36'd0},
    {32'd31535999,   1'b0, 36'd0},
    {32'd31536000,   1'b0, 36'd0},
    {32'd68169600,   1'b0, 36'd0},
    {32'd951782400,  1'b0, 36'd0},
    {32'd4102444800, 1'b0, 36'd0},
    {32'd4107456000, 1'b0, 36'd0},
    {32'd4107542400, 1'b0, 36'd0},
    {32'h7FFF_FFFF,  1'b0, 36'd0},
    {32'h8000_0000,  1'b0, 36'd0},
    {32'hAAAA_AAAA,  1'b0, 36'd0},
    {32'h5555_5555,  1'b0, 36'd0}
  };

  epoch_seconds_to_calendar_date_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_year_code        (out_year_code),
    .out_month_number     (out_month_number),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .out_weekday          (out_weekday)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic civil_leap(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  function automatic int unsigned civil_year_len(input int unsigned yr);
    return civil_leap(yr) ? 366 : 365;
  endfunction

  function automatic int unsigned civil_month_len(input int unsigned yr,
                                                  input int unsigned mon);
    int unsigned len;
    case (mon)
      4, 6, 9, 11: len = 30;
      2:           len = civil_leap(yr) ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic civil_date_t civil_from_epoch(input logic [31:0] t);
    int unsigned days;
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    civil_date_t d;
    days = t / 86400;
    sod  = t % 86400;
    d.weekday = 3'(((days + 4) % 7) + 1);
    yr = 1970;
    while (days >= civil_year_len(yr)) begin
      days -= civil_year_len(yr);
      yr++;
    end
    mon = 1;
    while (mon < 12 && days >= civil_month_len(yr, mon)) begin
      days -= civil_month_len(yr, mon);
      mon++;
    end
    d.year_code        = 7'((yr >= 2000) ? (yr - 2000) : (yr - 1900));
    d.month_number     = 4'(mon);
    d.day_of_month     = 5'(days + 1);
    d.hour_of_day      = 5'(sod / 3600);
    d.minute_of_hour   = 6'((sod % 3600) / 60);
    d.second_of_minute = 6'(sod % 60);
    return d;
  endfunction

  // uniform counts mixed with counts sitting on year and month edges
  function automatic logic [31:0] pick_epoch();
    int unsigned kind;
    int unsigned yr;
    int unsigned mon;
    int unsigned y;
    int unsigned m;
    int unsigned sod;
    longint      dayno;
    longint      secs;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom;
    yr = $urandom_range(1970, 2106);
    dayno = 0;
    for (y = 1970; y < yr; y++) dayno += civil_year_len(y);
    if (kind < 7) begin
      dayno -= $urandom_range(0, 1);
    end else begin
      mon = $urandom_range(1, 12);
      for (m = 1; m < mon; m++) dayno += civil_month_len(yr, m);
      case ($urandom_range(0, 2))
        0:       dayno += civil_month_len(yr, mon) - 1;
        1:       dayno += $urandom_range(0, civil_month_len(yr, mon) - 1);
        default: dayno += 0;
      endcase
    end
    if (dayno < 0) dayno = 0;
    case ($urandom_range(0, 2))
      0:       sod = 0;
      1:       sod = 86399;
      default: sod = $urandom_range(0, 86399);
    endcase
    secs = dayno * 86400 + sod;
    return secs[31:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 40);
    return $urandom_range(41, 220);
  endfunction

  task automatic send_epoch(input logic [31:0] t, input logic golden_ok,
                            input civil_date_t golden);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_epoch_seconds <= $urandom;
        @(posedge clk);
      end
    end
    start            <= 1'b1;
    in_epoch_seconds <= t;
    do @(posedge clk); while (busy);
    pending_dates.push_back(golden_ok ? golden : civil_from_epoch(t));
    beats_sent++;
    if (t < Y2K_EPOCH) pre2000_beats++;
  endtask

  always @(posedge clk) begin
    civil_date_t want;
    civil_date_t got;
    if (rst_n && out_valid) begin
      got = {out_year_code, out_month_number, out_day_of_month, out_hour_of_day,
             out_minute_of_hour, out_second_of_minute, out_weekday};
      if (pending_dates.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected date beat: %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                   got.year_code, got.month_number, got.day_of_month,
                   got.hour_of_day, got.minute_of_hour, got.second_of_minute,
                   got.weekday);
      end else begin
        want = pending_dates.pop_front();
        dates_checked++;
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("date %0d mismatch: exp %0d-%0d-%0d %0d:%0d:%0d wd %0d, %s%0d-%0d-%0d %0d:%0d:%0d wd %0d",
                     dates_checked, want.year_code, want.month_number,
                     want.day_of_month, want.hour_of_day, want.minute_of_hour,
                     want.second_of_minute, want.weekday, "got ",
                     got.year_code, got.month_number, got.day_of_month,
                     got.hour_of_day, got.minute_of_hour, got.second_of_minute,
                     got.weekday);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d dates outstanding",
               idle_cycles, pending_dates.size());
      $display("epoch_seconds_to_calendar_date_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    beats_sent    = 0;
    dates_checked = 0;
    pre2000_beats = 0;
    mismatch_cnt  = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIR; i++)
      send_epoch(dir_rows[i].epoch, dir_rows[i].golden_ok, dir_rows[i].golden);
    for (i = 0; i < NUM_RANDOM; i++)
      send_epoch(pick_epoch(), 1'b0, '0);

    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d beats (%0d before 2000), compared %0d dates",
             beats_sent, pre2000_beats, dates_checked);
    $display("mismatches: %0d", mismatch_cnt);
    if (mismatch_cnt == 0 && pending_dates.size() == 0) begin
      $display("epoch_seconds_to_calendar_date_unit_tb: done, clean");
    end else begin
      $display("epoch_seconds_to_calendar_date_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== epoch_seconds_to_calendar_date_unit.f =====
hw/rtl/ecd_pkg.sv
hw/rtl/ecd_alu.sv
hw/rtl/epoch_seconds_to_calendar_date_unit.sv
dv/epoch_seconds_to_calendar_date_unit_tb.sv
